// ----- rtl/assert_macros.svh -----
// Assertion macros for the time-of-day counter RTL.
// No dependencies; take in by `include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/hmsc_pkg.sv -----
// Shared types and constants of the time-of-day counter.
// No dependencies; used by hmsc_ctrl, hmsc_dp and the top level.
`default_nettype none

package hmsc_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MS_W   = 10;
  localparam int unsigned MINS_W = 12;
  localparam int unsigned SOD_W  = 17;
  localparam int unsigned TOT_W  = 13;

  localparam logic [MS_W-1:0]   MS_MAX   = 10'd999;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [TOT_W-1:0]  DAY_MINUTES  = 13'd1440;
  localparam logic [TOT_W-1:0]  MIN_PER_HOUR = 13'd60;
  localparam logic signed [MINS_W-1:0] OFFSET_MAX = 12'sd1440;
  localparam logic signed [MINS_W-1:0] OFFSET_MIN = -12'sd1440;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_UP    = 3'd0,
    FUNC_DOWN  = 3'd1,
    FUNC_SET   = 3'd2,
    FUNC_WARP  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_NORM,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic norm_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  norm_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/hmsc_ctrl.sv -----
// Controller of the time-of-day counter: sequencing FSM and output valid.
// Depends on hmsc_pkg.
`default_nettype none

module hmsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire hmsc_pkg::dp_sts_t sts_i,
  output hmsc_pkg::dp_cmd_t      cmd_o
);

  hmsc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hmsc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = hmsc_pkg::ST_EXEC;
      end
      hmsc_pkg::ST_EXEC: begin
        if (sts_i.func == hmsc_pkg::FUNC_WARP) state_d = hmsc_pkg::ST_NORM;
        else state_d = hmsc_pkg::ST_RESP;
      end
      hmsc_pkg::ST_NORM: begin
        if (sts_i.norm_last) state_d = hmsc_pkg::ST_RESP;
      end
      hmsc_pkg::ST_RESP: begin
        if (out_free) state_d = hmsc_pkg::ST_IDLE;
      end
      default: state_d = hmsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      hmsc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      hmsc_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      hmsc_pkg::ST_NORM: cmd_o.norm_step = 1'b1;
      hmsc_pkg::ST_RESP: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Set on a result load, drop once the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/hmsc_dp.sv -----
// Datapath of the time-of-day counter: request latch, time counters,
// warp normaliser and result register. Depends on hmsc_pkg.
`default_nettype none

module hmsc_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hmsc_pkg::dp_cmd_t                   cmd_i,
  output hmsc_pkg::dp_sts_t                        sts_o,
  input  wire logic        [hmsc_pkg::FUNC_W-1:0]  func_i,
  input  wire logic        [hmsc_pkg::HOUR_W-1:0]  set_hour_i,
  input  wire logic signed [hmsc_pkg::MINS_W-1:0]  minutes_i,
  input  wire logic        [hmsc_pkg::SEC_W-1:0]   set_second_i,
  output logic             [hmsc_pkg::HOUR_W-1:0]  hour_o,
  output logic             [hmsc_pkg::MIN_W-1:0]   minute_o,
  output logic             [hmsc_pkg::SEC_W-1:0]   second_o,
  output logic             [hmsc_pkg::MS_W-1:0]    millisecond_o,
  output logic             [hmsc_pkg::SOD_W-1:0]   seconds_of_day_o,
  output logic                                     expired_o
);

  // Request latch
  hmsc_pkg::func_e                      func_q;
  logic        [hmsc_pkg::HOUR_W-1:0]   set_hour_q;
  logic signed [hmsc_pkg::MINS_W-1:0]   minutes_q;
  logic        [hmsc_pkg::SEC_W-1:0]    set_second_q;

  // Time counters
  logic [hmsc_pkg::HOUR_W-1:0] hour_q, hour_d;
  logic [hmsc_pkg::MIN_W-1:0]  minute_q, minute_d;
  logic [hmsc_pkg::SEC_W-1:0]  second_q, second_d;
  logic [hmsc_pkg::MS_W-1:0]   milli_q, milli_d;
  logic                        expired_q, expired_d;

  // Warp normaliser
  logic [hmsc_pkg::TOT_W-1:0]  total_q, total_d;
  logic [hmsc_pkg::HOUR_W-1:0] quot_q, quot_d;

  logic                              all_zero;
  logic signed [hmsc_pkg::MINS_W-1:0] offset;
  logic [10:0]                       hm_minutes;
  logic signed [hmsc_pkg::TOT_W:0]   warp_sum;
  logic [hmsc_pkg::SOD_W-1:0]        sod;

  assign all_zero = (hour_q == '0) && (minute_q == '0) && (second_q == '0) && (milli_q == '0);

  always_comb begin
    if (minutes_q > hmsc_pkg::OFFSET_MAX) offset = hmsc_pkg::OFFSET_MAX;
    else if (minutes_q < hmsc_pkg::OFFSET_MIN) offset = hmsc_pkg::OFFSET_MIN;
    else offset = minutes_q;
  end

  assign hm_minutes = ({6'd0, hour_q} * 11'd60) + {5'd0, minute_q};
  assign warp_sum   = $signed({3'b000, hm_minutes})
                    + $signed({{2{offset[hmsc_pkg::MINS_W-1]}}, offset})
                    + $signed({1'b0, hmsc_pkg::DAY_MINUTES});

  always_comb begin
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    milli_d   = milli_q;
    expired_d = expired_q;
    total_d   = total_q;
    quot_d    = quot_q;
    if (cmd_i.exec) begin
      expired_d = 1'b0;
      case (func_q)
        hmsc_pkg::FUNC_UP: begin
          if (milli_q < hmsc_pkg::MS_MAX) milli_d = milli_q + 10'd1;
          else begin
            milli_d = '0;
            if (second_q < hmsc_pkg::SEC_MAX) second_d = second_q + 6'd1;
            else begin
              second_d = '0;
              if (minute_q < hmsc_pkg::MIN_MAX) minute_d = minute_q + 6'd1;
              else begin
                minute_d = '0;
                if (hour_q < hmsc_pkg::HOUR_MAX) hour_d = hour_q + 5'd1;
                else hour_d = '0;
              end
            end
          end
        end
        hmsc_pkg::FUNC_DOWN: begin
          // Hold at midnight and flag expiry.
          if (all_zero) expired_d = 1'b1;
          else if (milli_q != '0) milli_d = milli_q - 10'd1;
          else begin
            milli_d = hmsc_pkg::MS_MAX;
            if (second_q != '0) second_d = second_q - 6'd1;
            else begin
              second_d = hmsc_pkg::SEC_MAX;
              if (minute_q != '0) minute_d = minute_q - 6'd1;
              else begin
                minute_d = hmsc_pkg::MIN_MAX;
                hour_d   = hour_q - 5'd1;
              end
            end
          end
        end
        hmsc_pkg::FUNC_SET: begin
          hour_d = (set_hour_q > hmsc_pkg::HOUR_MAX) ? hmsc_pkg::HOUR_MAX : set_hour_q;
          if (minutes_q < 0) minute_d = '0;
          else if (minutes_q > $signed({6'd0, hmsc_pkg::MIN_MAX})) minute_d = hmsc_pkg::MIN_MAX;
          else minute_d = minutes_q[hmsc_pkg::MIN_W-1:0];
          second_d = (set_second_q > hmsc_pkg::SEC_MAX) ? hmsc_pkg::SEC_MAX : set_second_q;
        end
        hmsc_pkg::FUNC_WARP: begin
          total_d = warp_sum[hmsc_pkg::TOT_W-1:0];
          quot_d  = '0;
        end
        hmsc_pkg::FUNC_CLEAR: begin
          hour_d   = '0;
          minute_d = '0;
          second_d = '0;
          milli_d  = '0;
        end
        default: ;
      endcase
    end else if (cmd_i.norm_step) begin
      // Fold the day first, then peel off hours one at a time.
      if (total_q >= hmsc_pkg::DAY_MINUTES) total_d = total_q - hmsc_pkg::DAY_MINUTES;
      else if (total_q >= hmsc_pkg::MIN_PER_HOUR) begin
        total_d = total_q - hmsc_pkg::MIN_PER_HOUR;
        quot_d  = quot_q + 5'd1;
      end else begin
        hour_d   = quot_q;
        minute_d = total_q[hmsc_pkg::MIN_W-1:0];
      end
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.norm_last = (total_q < hmsc_pkg::MIN_PER_HOUR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q    <= '0;
      minute_q  <= '0;
      second_q  <= '0;
      milli_q   <= '0;
      expired_q <= 1'b0;
    end else begin
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      second_q  <= second_d;
      milli_q   <= milli_d;
      expired_q <= expired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    quot_q  <= quot_d;
    if (cmd_i.load_in) begin
      func_q       <= hmsc_pkg::func_e'(func_i);
      set_hour_q   <= set_hour_i;
      minutes_q    <= minutes_i;
      set_second_q <= set_second_i;
    end
  end

  assign sod = ({12'd0, hour_q} * 17'd3600) + ({11'd0, minute_q} * 17'd60)
             + {11'd0, second_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hour_o           <= hour_q;
      minute_o         <= minute_q;
      second_o         <= second_q;
      millisecond_o    <= milli_q;
      seconds_of_day_o <= sod;
      expired_o        <= expired_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hms_millisecond_up_down_clock_top.sv -----
// Top level of the time-of-day counter: controller plus datapath.
// Depends on hmsc_pkg, hmsc_ctrl, hmsc_dp and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Time-of-day counter in hours, minutes, seconds and milliseconds. Each
// request on the input channel carries one operation in func_i: count up one
// millisecond (wrapping at 23:59:59.999), count down one millisecond (holding
// at 00:00:00.000 and raising expired_o when already there), set hours,
// minutes and seconds with saturation while keeping the milliseconds, warp by
// a signed minute offset (saturated to one day) modulo 24 hours, or clear.
// Unused codes leave the time as it is. Each request yields exactly one
// result carrying the time and its seconds of the day. Requests are handled
// one at a time. For count, set, clear and unused codes the operation is
// executed and the result register then loaded. A warp adds normalisation
// steps in between: up to two subtractions of a day, up to 23 subtractions
// of an hour and a closing step that writes hour and minute, so at most 26
// steps. The result sits in an output register, and its load waits until
// any earlier result has been taken; the next request is accepted as soon as
// that register has been loaded, even while the result still waits to be
// taken. Reset clears the time to midnight; there is no configuration.
module hms_millisecond_up_down_clock_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [hmsc_pkg::FUNC_W-1:0]  func_i,
  input  wire logic        [hmsc_pkg::HOUR_W-1:0]  set_hour_i,
  input  wire logic signed [hmsc_pkg::MINS_W-1:0]  minutes_i,
  input  wire logic        [hmsc_pkg::SEC_W-1:0]   set_second_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [hmsc_pkg::HOUR_W-1:0]  hour_o,
  output logic             [hmsc_pkg::MIN_W-1:0]   minute_o,
  output logic             [hmsc_pkg::SEC_W-1:0]   second_o,
  output logic             [hmsc_pkg::MS_W-1:0]    millisecond_o,
  output logic             [hmsc_pkg::SOD_W-1:0]   seconds_of_day_o,
  output logic                                     expired_o
);

  // Command and status between sequencer and datapath
  hmsc_pkg::dp_cmd_t cmd;
  hmsc_pkg::dp_sts_t sts;

  // Checks on the presented result
  logic time_legal;
  logic at_midnight;

  hmsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hmsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .set_hour_i       (set_hour_i),
    .minutes_i        (minutes_i),
    .set_second_i     (set_second_i),
    .hour_o           (hour_o),
    .minute_o         (minute_o),
    .second_o         (second_o),
    .millisecond_o    (millisecond_o),
    .seconds_of_day_o (seconds_of_day_o),
    .expired_o        (expired_o)
  );

  assign time_legal  = (hour_o <= hmsc_pkg::HOUR_MAX) && (minute_o <= hmsc_pkg::MIN_MAX)
                     && (second_o <= hmsc_pkg::SEC_MAX) && (millisecond_o <= hmsc_pkg::MS_MAX);
  assign at_midnight = (seconds_of_day_o == '0) && (millisecond_o == '0);

  // A presented result always holds a legal time of day.
  `ASSERT_IMPLY(a_time_legal, clk_i, rst_ni, out_valid_o, time_legal)

  // Expiry is only ever reported at midnight.
  `ASSERT_IMPLY(a_expired_midnight, clk_i, rst_ni, out_valid_o && expired_o, at_midnight)

  // Only one request is in flight at a time.
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

`default_nettype wire
